@@ rtl/conv2d_hwc_mac_engine_assert.svh @@
// ---------------------------------------------------------------------------
// conv2d_hwc_mac_engine assertion macros
// Clocked on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef CONV2D_HWC_MAC_ENGINE_ASSERT_SVH
`define CONV2D_HWC_MAC_ENGINE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define C2D_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("c2d assertion failed");

// antecedent implies consequent in the next cycle
`define C2D_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("c2d assertion failed");

`endif

@@ rtl/c2d_pkg.sv @@
// ---------------------------------------------------------------------------
// c2d_pkg
// Shared types and constants of the Q8.8 convolution engine.
// ---------------------------------------------------------------------------
`default_nettype none

package c2d_pkg;

   localparam int ACT_DEPTH    = 65536;
   localparam int WEIGHT_DEPTH = 65536;
   localparam int MAX_CHANNELS = 64;
   localparam int MAX_DIM      = 64;
   localparam int MAX_KERNEL   = 7;

   localparam int ACT_AW  = $clog2(ACT_DEPTH);
   localparam int WT_AW   = $clog2(WEIGHT_DEPTH);
   localparam int BIAS_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   // wide enough for any tap address the loops can form
   localparam int ADDR_W = 20;
   localparam int ACC_W  = 44;

   localparam int CSR_NUM = 8;
   localparam logic [2:0] CSR_IH = 3'd0;
   localparam logic [2:0] CSR_IW = 3'd1;
   localparam logic [2:0] CSR_IC = 3'd2;
   localparam logic [2:0] CSR_OH = 3'd3;
   localparam logic [2:0] CSR_OW = 3'd4;
   localparam logic [2:0] CSR_OC = 3'd5;
   localparam logic [2:0] CSR_KH = 3'd6;
   localparam logic [2:0] CSR_KW = 3'd7;

   localparam logic [1:0] KIND_WEIGHT  = 2'd0;
   localparam logic [1:0] KIND_BIAS    = 2'd1;
   localparam logic [1:0] KIND_ACT     = 2'd2;
   localparam logic [1:0] KIND_COMPUTE = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic [15:0]        index;
      logic signed [15:0] value;
      logic [5:0]         out_row;
      logic [5:0]         out_col;
   } req_type;

   typedef struct packed {
      logic [5:0]         out_channel;
      logic signed [15:0] out_value;
      logic               last;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic latch;
      logic err;
      logic setup1;
      logic setup2;
      logic chan_start;
      logic step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic pix_bad;
      logic tap_last;
      logic chan_last;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/c2d_ram.sv @@
// ---------------------------------------------------------------------------
// c2d_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module c2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/c2d_ctrl.sv @@
// ---------------------------------------------------------------------------
// c2d_ctrl
// Sequencer: setup, per-channel tap walk, pipeline drain and result emit.
// ---------------------------------------------------------------------------
`default_nettype none

module c2d_ctrl import c2d_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [1:0] kind,
   input  wire sts_type    sts,
   output cmd_type         cmd,
   output logic            busy
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETUP1 = 3'd1;
   localparam logic [2:0] ST_SETUP2 = 3'd2;
   localparam logic [2:0] ST_CHAN   = 3'd3;
   localparam logic [2:0] ST_RUN    = 3'd4;
   localparam logic [2:0] ST_DRAIN1 = 3'd5;
   localparam logic [2:0] ST_DRAIN2 = 3'd6;
   localparam logic [2:0] ST_EMIT   = 3'd7;

   logic [2:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (kind != KIND_COMPUTE) begin
                  cmd.load = 1'b1;
               end else if (sts.pix_bad) begin
                  cmd.err = 1'b1;
               end else begin
                  cmd.latch = 1'b1;
                  state_in  = ST_SETUP1;
               end
            end
         end
         ST_SETUP1: begin
            cmd.setup1 = 1'b1;
            state_in   = ST_SETUP2;
         end
         ST_SETUP2: begin
            cmd.setup2 = 1'b1;
            state_in   = ST_CHAN;
         end
         ST_CHAN: begin
            cmd.chan_start = 1'b1;
            state_in       = ST_RUN;
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (sts.tap_last) begin
               state_in = ST_DRAIN1;
            end
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_EMIT;
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = sts.chan_last ? ST_IDLE : ST_CHAN;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/c2d_datapath.sv @@
// ---------------------------------------------------------------------------
// c2d_datapath
// Registers, stores, tap address walk, MAC pipeline and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module c2d_datapath import c2d_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    req_payload,
   input  wire logic       csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [6:0] csr_data,
   input  wire cmd_type    cmd,
   output sts_type         sts,
   output logic            rsp_valid,
   output rsp_type         rsp_payload
);

   function automatic logic [6:0] clamp(input logic [6:0] v, input int hi);
      logic [6:0] r;
      if (v == 7'd0) r = 7'd1;
      else if (int'(v) > hi) r = 7'(hi);
      else r = v;
      return r;
   endfunction

   // configuration registers
   logic [6:0] cfg_ff [CSR_NUM];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[CSR_IH] <= 7'd8;
         cfg_ff[CSR_IW] <= 7'd8;
         cfg_ff[CSR_IC] <= 7'd1;
         cfg_ff[CSR_OH] <= 7'd6;
         cfg_ff[CSR_OW] <= 7'd6;
         cfg_ff[CSR_OC] <= 7'd1;
         cfg_ff[CSR_KH] <= 7'd3;
         cfg_ff[CSR_KW] <= 7'd3;
      end else if (csr_we) begin
         if (csr_index == CSR_KH || csr_index == CSR_KW) begin
            cfg_ff[csr_index] <= {4'd0, csr_data[2:0]};
         end else begin
            cfg_ff[csr_index] <= csr_data;
         end
      end
   end

   logic [6:0] ih_c, iw_c, ic_c, oh_c, ow_c, oc_c, kh_c, kw_c;
   assign ih_c = clamp(cfg_ff[CSR_IH], MAX_DIM);
   assign iw_c = clamp(cfg_ff[CSR_IW], MAX_DIM);
   assign ic_c = clamp(cfg_ff[CSR_IC], MAX_CHANNELS);
   assign oh_c = clamp(cfg_ff[CSR_OH], MAX_DIM);
   assign ow_c = clamp(cfg_ff[CSR_OW], MAX_DIM);
   assign oc_c = clamp(cfg_ff[CSR_OC], MAX_CHANNELS);
   assign kh_c = clamp(cfg_ff[CSR_KH], MAX_KERNEL);
   assign kw_c = clamp(cfg_ff[CSR_KW], MAX_KERNEL);

   assign sts.pix_bad = ({1'b0, req_payload.out_row} >= oh_c) ||
                        ({1'b0, req_payload.out_col} >= ow_c);

   // load decode
   logic [ADDR_W-1:0] ld_idx;
   logic              wt_we, bias_we, act_we;
   assign ld_idx  = {{(ADDR_W-16){1'b0}}, req_payload.index};
   assign wt_we   = cmd.load && (req_payload.kind == KIND_WEIGHT) &&
                    (ld_idx < ADDR_W'(WEIGHT_DEPTH));
   assign bias_we = cmd.load && (req_payload.kind == KIND_BIAS) &&
                    (ld_idx < ADDR_W'(MAX_CHANNELS));
   assign act_we  = cmd.load && (req_payload.kind == KIND_ACT) &&
                    (ld_idx < ADDR_W'(ACT_DEPTH));

   // setup: pixel origin and row stride
   logic [5:0]        orow_ff, ocol_ff;
   logic [12:0]       p1_ff;
   logic [13:0]       stride_ff;
   logic [ADDR_W-1:0] base_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         orow_ff <= req_payload.out_row;
         ocol_ff <= req_payload.out_col;
      end
      if (cmd.setup1) begin
         p1_ff     <= 13'({1'b0, orow_ff} * iw_c);
         stride_ff <= 14'(iw_c * ic_c);
      end
      if (cmd.setup2) begin
         base_ff <= ADDR_W'(({1'b0, p1_ff} + {8'd0, ocol_ff}) * {7'd0, ic_c});
      end
   end

   // tap walk counters
   logic [6:0]        co_ff, ci_ff;
   logic [2:0]        r_ff, c_ff;
   logic [ADDR_W-1:0] aa_ff, aarow_ff, wa_ff;
   logic              ci_last, c_last, r_last;

   assign ci_last = (ci_ff == ic_c - 7'd1);
   assign c_last  = ({4'd0, c_ff} == kw_c - 7'd1);
   assign r_last  = ({4'd0, r_ff} == kh_c - 7'd1);
   assign sts.tap_last  = ci_last && c_last && r_last;
   assign sts.chan_last = (co_ff == oc_c - 7'd1);

   always_ff @(posedge clock) begin
      if (cmd.setup1) begin
         co_ff <= 7'd0;
      end else if (cmd.emit) begin
         co_ff <= co_ff + 7'd1;
      end
      if (cmd.chan_start) begin
         ci_ff    <= 7'd0;
         c_ff     <= 3'd0;
         r_ff     <= 3'd0;
         aa_ff    <= base_ff;
         aarow_ff <= base_ff;
         wa_ff    <= {{(ADDR_W-7){1'b0}}, co_ff};
      end else if (cmd.step) begin
         wa_ff <= wa_ff + {{(ADDR_W-7){1'b0}}, oc_c};
         if (ci_last) begin
            ci_ff <= 7'd0;
            if (c_last) begin
               c_ff     <= 3'd0;
               r_ff     <= r_ff + 3'd1;
               aarow_ff <= aarow_ff + {{(ADDR_W-14){1'b0}}, stride_ff};
               aa_ff    <= aarow_ff + {{(ADDR_W-14){1'b0}}, stride_ff};
            end else begin
               c_ff  <= c_ff + 3'd1;
               aa_ff <= aa_ff + ADDR_W'(1);
            end
         end else begin
            ci_ff <= ci_ff + 7'd1;
            aa_ff <= aa_ff + ADDR_W'(1);
         end
      end
   end

   // tap inside input and stores
   logic [6:0] hin, win;
   logic       tap_ok;
   assign hin    = {1'b0, orow_ff} + {4'd0, r_ff};
   assign win    = {1'b0, ocol_ff} + {4'd0, c_ff};
   assign tap_ok = (hin < ih_c) && (win < iw_c) &&
                   (aa_ff < ADDR_W'(ACT_DEPTH)) && (wa_ff < ADDR_W'(WEIGHT_DEPTH));

   // stores
   logic [15:0] act_rd, wt_rd, bias_rd;

   c2d_ram #(.WIDTH(16), .DEPTH(ACT_DEPTH)) u_act_ram (
      .clock   (clock),
      .wr_en   (act_we),
      .wr_addr (ld_idx[ACT_AW-1:0]),
      .wr_data (req_payload.value),
      .rd_addr (aa_ff[ACT_AW-1:0]),
      .rd_data (act_rd)
   );

   c2d_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_wt_ram (
      .clock   (clock),
      .wr_en   (wt_we),
      .wr_addr (ld_idx[WT_AW-1:0]),
      .wr_data (req_payload.value),
      .rd_addr (wa_ff[WT_AW-1:0]),
      .rd_data (wt_rd)
   );

   c2d_ram #(.WIDTH(16), .DEPTH(MAX_CHANNELS)) u_bias_ram (
      .clock   (clock),
      .wr_en   (bias_we),
      .wr_addr (ld_idx[BIAS_AW-1:0]),
      .wr_data (req_payload.value),
      .rd_addr (co_ff[BIAS_AW-1:0]),
      .rd_data (bias_rd)
   );

   // MAC pipeline: read, multiply, accumulate
   logic                    v1_ff, v2_ff, init_ff;
   logic signed [31:0]      prod_ff;
   logic signed [ACC_W-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         init_ff <= 1'b0;
      end else begin
         v1_ff   <= cmd.step && tap_ok;
         v2_ff   <= v1_ff;
         init_ff <= cmd.chan_start;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= $signed(act_rd) * $signed(wt_rd);
      if (init_ff) begin
         acc_ff <= ACC_W'($signed({bias_rd, 8'd0}));
      end else if (v2_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // floor shift and saturate
   logic signed [ACC_W-1:0] sh;
   logic signed [15:0]      sat;
   always_comb begin
      sh = acc_ff >>> 8;
      if (sh > ACC_W'(32767)) sat = 16'sh7fff;
      else if (sh < -ACC_W'(32768)) sat = 16'sh8000;
      else sat = sh[15:0];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.emit || cmd.err;
      end
      if (cmd.err) begin
         rsp_payload <= '{out_channel: 6'd0, out_value: 16'sd0, last: 1'b1, status: 1'b1};
      end else if (cmd.emit) begin
         rsp_payload <= '{out_channel: co_ff[5:0], out_value: sat,
                          last: sts.chan_last, status: 1'b0};
      end
   end

endmodule

`default_nettype wire

@@ rtl/conv2d_hwc_mac_engine.sv @@
// ---------------------------------------------------------------------------
// conv2d_hwc_mac_engine
// Stride-one Q8.8 2-D convolution with bias over HWC activations.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Load requests
// (weight, bias, activation) leave busy low. A pixel request outside the
// output size returns one error result on the cycle after it is taken. A
// valid pixel request holds busy through setup and then, for each output
// channel, one multiply-accumulate per tap through a single MAC behind the
// store read ports, plus the states that start the channel's tap walk,
// drain the read and multiply registers of the MAC pipeline and
// emit. Each channel's result appears the cycle after its emit, so the last
// one comes in the first cycle that busy is low again. Results appear on
// rsp_payload for exactly one cycle with rsp_valid high; the receiver cannot
// stall and must take each one. Configuration writes are taken in any cycle
// (csr_ready is held high) and must only be issued while the block is idle.
`default_nettype none
`include "conv2d_hwc_mac_engine_assert.svh"

module conv2d_hwc_mac_engine import c2d_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire req_type    req_payload,
   output logic            rsp_valid,
   output rsp_type         rsp_payload,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [2:0] csr_index,
   input  wire logic [6:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   c2d_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .kind  (req_payload.kind),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   c2d_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // error results are single and zero
   `C2D_ASSERT_NOW(a_err_last, rsp_valid && rsp_payload.status, rsp_payload.last)
   `C2D_ASSERT_NOW(a_err_zero, rsp_valid && rsp_payload.status,
      rsp_payload.out_value == 16'sd0 && rsp_payload.out_channel == 6'd0)
   // loads never make the block busy
   `C2D_ASSERT_NEXT(a_load_idle, start && !busy && req_payload.kind != KIND_COMPUTE, !busy)
   // no result follows an idle cycle unless a pixel request was taken in it
   `C2D_ASSERT_NEXT(a_rsp_src, !busy && !(start && req_payload.kind == KIND_COMPUTE),
      !rsp_valid)

endmodule

`default_nettype wire
